// File: rtl/core/rbm_pkg.sv
// Shared types and constants of the RGBA blend mode unit.
`default_nettype none

package rbm_pkg;

  localparam int unsigned CompWidth = 8;
  localparam int unsigned NumComps  = 4;
  localparam int unsigned DivLanes  = 3;
  localparam int unsigned QuotBits  = 8;
  localparam int unsigned ProdWidth = 2 * CompWidth;

  localparam logic [CompWidth-1:0] CompMax    = 8'hFF;
  localparam logic [ProdWidth-1:0] ScreenBias = 16'd127;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_SCREEN = 2'd1,
    MODE_DIFF   = 2'd2,
    MODE_DODGE  = 2'd3
  } blend_mode_e;

  typedef logic [NumComps-1:0][CompWidth-1:0] pixel_t;

  // One pixel in flight through the cell chain.
  typedef struct packed {
    blend_mode_e                                mode;
    logic [NumComps-1:0][CompWidth-1:0]         simple;
    logic [NumComps-1:0][ProdWidth-1:0]         prod;
    logic [DivLanes-1:0]                        sat;
    logic [DivLanes-1:0][ProdWidth-1:0]         rem;
    logic [DivLanes-1:0][CompWidth-1:0]         dsr;
    logic [DivLanes-1:0][QuotBits-1:0]          quot;
  } rbm_item_t;

endpackage

`default_nettype wire

// File: rtl/core/rgba_blend_mode_unit.sv
// Top level of the RGBA blend mode unit: entry stage, divider cell chain, output register.
//
// The unit blends a source and a destination RGBA pixel (8-bit components
// standing for value/255) under the mode held in its one configuration
// register: add, screen, difference or color dodge. It takes one pixel in
// every clock cycle while the chain advances, and delivers each result
// through ten register stages: one entry stage, a chain of eight
// divider cells that each settle one quotient bit of the color dodge
// division, and the output register.
// The whole chain moves forward together; it holds only while a finished
// result sits in the output register and the receiver stalls, so the input
// is stalled exactly in those cycles. The mode is written through the
// configuration channel, which is always ready, and takes effect for pixels
// transferred after the write; it should be changed only while no pixel is
// in flight. Each pixel carries its mode along the chain.
`default_nettype none

module rgba_blend_mode_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration write channel
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_data_i,
  // Input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] src_red_i,
  input  wire logic [7:0] src_green_i,
  input  wire logic [7:0] src_blue_i,
  input  wire logic [7:0] src_alpha_i,
  input  wire logic [7:0] dst_red_i,
  input  wire logic [7:0] dst_green_i,
  input  wire logic [7:0] dst_blue_i,
  input  wire logic [7:0] dst_alpha_i,
  // Output channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_red_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_blue_o,
  output logic [7:0]      out_alpha_o
);
  import rbm_pkg::*;

  // Mode register.
  blend_mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ADD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= blend_mode_e'(cfg_data_i);
    end
  end

  assign cfg_ready_o = 1'b1;

  // The chain advances unless a result is waiting and the receiver stalls.
  logic advance;
  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;

  pixel_t src, dst;
  assign src = {src_alpha_i, src_blue_i, src_green_i, src_red_i};
  assign dst = {dst_alpha_i, dst_blue_i, dst_green_i, dst_red_i};

  // Stage 0 is the entry stage, stages 1 to QuotBits the divider cells.
  logic      [QuotBits:0] stage_valid;
  rbm_item_t              stage_item [QuotBits+1];

  rbm_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_valid_i),
    .mode_i  (mode_q),
    .src_i   (src),
    .dst_i   (dst),
    .valid_o (stage_valid[0]),
    .item_o  (stage_item[0])
  );

  // The first cell resolves the most significant quotient bit.
  for (genvar g = 0; g < QuotBits; g++) begin : g_cell
    rbm_cell #(
      .Step (QuotBits - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (stage_valid[g]),
      .item_i  (stage_item[g]),
      .valid_o (stage_valid[g+1]),
      .item_o  (stage_item[g+1])
    );
  end

  // Output selection. The screen blend divides the rounded product by 255
  // through the identity floor(x/255) = (x + (x >> 8) + 1) >> 8, which holds
  // for every x below 65535.
  rbm_item_t last;
  pixel_t    res_d, res_q;
  logic      out_valid_q;

  assign last = stage_item[QuotBits];

  always_comb begin
    logic [ProdWidth-1:0] x, t;
    res_d = '0;
    for (int k = 0; k < NumComps; k++) begin
      x = last.prod[k] + ScreenBias;
      t = x + (x >> CompWidth) + ProdWidth'(1);
      case (last.mode)
        MODE_ADD:    res_d[k] = last.simple[k];
        MODE_SCREEN: res_d[k] = CompMax - t[ProdWidth-1:CompWidth];
        MODE_DIFF:   res_d[k] = last.simple[k];
        MODE_DODGE: begin
          if (k < DivLanes) begin
            res_d[k] = last.sat[k] ? CompMax : last.quot[k];
          end else begin
            res_d[k] = last.simple[k];
          end
        end
        default:     res_d[k] = last.simple[k];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= stage_valid[QuotBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = res_q[0];
  assign out_green_o = res_q[1];
  assign out_blue_o  = res_q[2];
  assign out_alpha_o = res_q[3];

  // An empty output register never blocks the input.
  a_no_stall_when_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o
  ) else $error("input stalled while the output register is empty");

  // A held result freezes the whole chain.
  a_chain_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(stage_valid)
  ) else $error("cell chain moved while the output was stalled");

  // A full destination red component always saturates the dodge lane.
  a_full_dst_saturates : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && dst_red_i == CompMax) |=> stage_item[0].sat[0]
  ) else $error("full destination did not mark the dodge lane saturated");

endmodule

`default_nettype wire

// File: rtl/core/rbm_prep.sv
// Entry stage: per-component add, difference or alpha maximum, products and divider setup.
`default_nettype none

module rbm_prep (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  rbm_pkg::blend_mode_e     mode_i,
  input  rbm_pkg::pixel_t          src_i,
  input  rbm_pkg::pixel_t          dst_i,
  output logic                     valid_o,
  output rbm_pkg::rbm_item_t       item_o
);
  import rbm_pkg::*;

  rbm_item_t item_d, item_q;
  logic      valid_q;

  always_comb begin
    logic [CompWidth:0]   sum;
    logic [CompWidth-1:0] s, d, inv_s, inv_d;
    logic [ProdWidth-1:0] dividend;
    item_d      = '0;
    item_d.mode = mode_i;
    for (int k = 0; k < NumComps; k++) begin
      s     = src_i[k];
      d     = dst_i[k];
      inv_s = ~s;
      inv_d = ~d;
      sum   = {1'b0, s} + {1'b0, d};
      if (mode_i == MODE_ADD) begin
        item_d.simple[k] = sum[CompWidth] ? CompMax : sum[CompWidth-1:0];
      end else if (k == NumComps - 1) begin
        item_d.simple[k] = (s >= d) ? s : d;
      end else begin
        item_d.simple[k] = (s >= d) ? (s - d) : (d - s);
      end
      // (255-s)*(255-d); the division by 255 happens at the output.
      item_d.prod[k] = {{CompWidth{1'b0}}, inv_s} * {{CompWidth{1'b0}}, inv_d};
      // Dividend is s*255; the quotient saturates once it reaches 256,
      // which also covers a full destination (divisor zero).
      dividend = {s, {CompWidth{1'b0}}} - {{CompWidth{1'b0}}, s};
      if (k < DivLanes) begin
        item_d.rem[k]     = dividend;
        item_d.dsr[k]     = inv_d;
        item_d.sat[k]     = dividend >= {inv_d, {CompWidth{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: rtl/core/rbm_cell.sv
// One divider cell: resolves a single quotient bit for each dodge lane.
`default_nettype none

module rbm_cell #(
  parameter int unsigned Step = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  rbm_pkg::rbm_item_t       item_i,
  output logic                     valid_o,
  output rbm_pkg::rbm_item_t       item_o
);
  import rbm_pkg::*;

  rbm_item_t item_d, item_q;
  logic      valid_q;

  always_comb begin
    logic [ProdWidth-1:0] dsh;
    item_d = item_i;
    for (int k = 0; k < DivLanes; k++) begin
      dsh = {{CompWidth{1'b0}}, item_i.dsr[k]} << Step;
      if (item_i.rem[k] >= dsh) begin
        item_d.rem[k]       = item_i.rem[k] - dsh;
        item_d.quot[k][Step] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: tb/sv/rgba_blend_mode_unit_tb.sv
// Self-checking testbench for the RGBA blend mode unit.
`timescale 1ns / 1ps

module rgba_blend_mode_unit_tb;
  import rbm_pkg::*;

  // Component positions inside a pixel_t: red is the low byte, alpha the high one.
  localparam int CompRed   = 0;
  localparam int CompGreen = 1;
  localparam int CompBlue  = 2;
  localparam int CompAlpha = 3;

  // The longest correct stretch without any transfer is shorter than the long
  // receiver hold plus a full pipeline. The watchdog allows far more.
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned DrainCycles  = 24;
  localparam int unsigned HoldStart    = 400;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned PhasePixels  = 160;
  localparam int unsigned MaxPrinted   = 40;

  // A source and a destination pixel, applied together in one input transfer.
  typedef struct packed {
    pixel_t src;
    pixel_t dst;
  } pixel_pair_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_data  = 2'd0;
  logic        cfg_ready;

  logic        in_valid  = 1'b0;
  logic        in_stall;
  pixel_pair_t cur_pair  = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;

  // Pixels waiting to be offered, and blended pixels the unit still owes us.
  pixel_pair_t pair_q[$];
  pixel_t      blended_q[$];

  // Our own copy of the mode register, updated when a write transfer completes.
  blend_mode_e mode_shadow = MODE_ADD;

  logic        src_idle_en  = 1'b1;
  logic        sink_idle_en = 1'b1;
  logic        rx_hold      = 1'b0;
  int unsigned src_gap      = 0;
  int unsigned sink_gap     = 0;

  int unsigned pix_count     = 0;
  int unsigned result_count  = 0;
  int unsigned stall_cycles  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  logic [3:0]  modes_seen    = '0;

  string comp_name[4] = '{"red", "green", "blue", "alpha"};

  always #2 clk = ~clk;

  rgba_blend_mode_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .src_red_i   (cur_pair.src[CompRed]),
    .src_green_i (cur_pair.src[CompGreen]),
    .src_blue_i  (cur_pair.src[CompBlue]),
    .src_alpha_i (cur_pair.src[CompAlpha]),
    .dst_red_i   (cur_pair.dst[CompRed]),
    .dst_green_i (cur_pair.dst[CompGreen]),
    .dst_blue_i  (cur_pair.dst[CompBlue]),
    .dst_alpha_i (cur_pair.dst[CompAlpha]),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_red_o   (out_red),
    .out_green_o (out_green),
    .out_blue_o  (out_blue),
    .out_alpha_o (out_alpha)
  );

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;
  wire cfg_fire = cfg_valid && cfg_ready;

  // Blends one component pair. Alpha takes the larger value in the difference
  // and color dodge modes; add and screen treat all four components alike.
  function automatic logic [7:0] blend_component(input logic [7:0] s, input logic [7:0] d,
                                                 input blend_mode_e mode, input bit is_alpha);
    int unsigned sv, dv, prod, quot;
    sv = s;
    dv = d;
    case (mode)
      MODE_ADD: begin
        return (sv + dv > 255) ? 8'd255 : 8'(sv + dv);
      end
      MODE_SCREEN: begin
        prod = (255 - sv) * (255 - dv);
        return 8'(255 - (prod + 127) / 255);
      end
      MODE_DIFF: begin
        if (is_alpha) return (s >= d) ? s : d;
        return (s >= d) ? s - d : d - s;
      end
      default: begin
        if (is_alpha) return (s >= d) ? s : d;
        // A full destination component saturates without a division.
        if (dv == 255) return 8'd255;
        quot = (sv * 255) / (255 - dv);
        return (quot > 255) ? 8'd255 : 8'(quot);
      end
    endcase
  endfunction

  function automatic pixel_t blend_pixel(input pixel_pair_t pair, input blend_mode_e mode);
    pixel_t res;
    for (int k = 0; k < 4; k++) begin
      res[k] = blend_component(pair.src[k], pair.dst[k], mode, k == CompAlpha);
    end
    return res;
  endfunction

  function automatic pixel_pair_t make_pair(input logic [7:0] sr, input logic [7:0] dr,
                                            input logic [7:0] sg, input logic [7:0] dg,
                                            input logic [7:0] sb, input logic [7:0] db,
                                            input logic [7:0] sa, input logic [7:0] da);
    pixel_pair_t p;
    p.src = {sa, sb, sg, sr};
    p.dst = {da, db, dg, dr};
    return p;
  endfunction

  // Random component values lean toward the edges of the range, where the
  // saturation and the dodge corner cases live.
  function automatic logic [7:0] random_component();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd254;
      3: return 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_pair_t random_pair();
    pixel_pair_t p;
    for (int k = 0; k < 4; k++) begin
      p.src[k] = random_component();
      // Equal pairs now and then give a zero difference and tie in the maximum.
      p.dst[k] = ($urandom_range(0, 7) == 0) ? p.src[k] : random_component();
    end
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxPrinted) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Waits until every queued pixel has been transferred and every result has come back.
  task automatic wait_drained();
    while (pair_q.size() != 0 || in_valid || blended_q.size() != 0) @(posedge clk);
  endtask

  // One write transfer on the configuration channel. The unit is idle here.
  task automatic write_mode(input blend_mode_e mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    mode_shadow = mode;
    cfg_writes++;
  endtask

  // Source side. After each transfer it draws how many cycles to leave the
  // channel empty; valid stays high across back-to-back transfers, and a
  // stalled pixel is held unchanged.
  always @(posedge clk) begin
    logic        next_valid;
    int unsigned next_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap  <= 0;
    end else begin
      next_valid = in_valid;
      next_gap   = src_gap;
      if (in_valid && in_stall) stall_cycles++;
      if (in_fire) begin
        blended_q.push_back(blend_pixel(cur_pair, mode_shadow));
        modes_seen[mode_shadow] = 1'b1;
        pix_count++;
        next_valid = 1'b0;
        next_gap   = src_idle_en ? $urandom_range(0, 5) : 0;
      end else if (!in_valid && next_gap != 0) begin
        next_gap--;
      end
      if (!next_valid && next_gap == 0 && pair_q.size() != 0) begin
        cur_pair   <= pair_q.pop_front();
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
      src_gap  <= next_gap;
    end
  end

  // Result side. Each accepted result is checked against the oldest prediction,
  // then the receiver draws how many cycles it stalls before the next one. The
  // long hold from the pressure process overrides everything.
  always @(posedge clk) begin
    int unsigned next_gap;
    pixel_t      got, want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_gap  <= 0;
    end else begin
      next_gap = sink_gap;
      if (out_fire) begin
        got = {out_alpha, out_blue, out_green, out_red};
        result_count++;
        if (blended_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no pixel pending", got));
        end else begin
          want = blended_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got[k] !== want[k]) begin
              report_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                                        result_count, comp_name[k], want[k], got[k]));
            end
          end
        end
        next_gap = sink_idle_en ? $urandom_range(0, 5) : 0;
      end else if (next_gap != 0) begin
        next_gap--;
      end
      sink_gap  <= next_gap;
      out_stall <= rx_hold || (next_gap != 0);
    end
  end

  // Pressure: in the middle of a random phase the receiver stops taking results
  // for a long stretch while the source keeps offering, so the pipeline fills
  // and the unit has to stall its input.
  initial begin
    while (pix_count < HoldStart) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog: a run that goes too long without any transfer is hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire || out_fire || cfg_fire) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transfer for %0d cycles", IdleLimit);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Main sequence: reset, a directed set under every mode (the first under the
  // reset value of the register), then random phases, each with its own mode
  // and idling pattern.
  initial begin
    pixel_pair_t directed[6];
    blend_mode_e mode_order[4];
    blend_mode_e phase_mode;

    // Zeros and full scale; a full destination for the dodge corner; dodge
    // saturation near a full destination; equal values; bit patterns that
    // drive every input bit both ways.
    directed[0] = make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    directed[1] = make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    directed[2] = make_pair(8'd255, 8'd0, 8'd0, 8'd255, 8'd128, 8'd127, 8'd1, 8'd254);
    directed[3] = make_pair(8'd255, 8'd254, 8'd1, 8'd254, 8'd100, 8'd100, 8'd0, 8'd200);
    directed[4] = make_pair(8'd200, 8'd100, 8'd100, 8'd200, 8'd127, 8'd128, 8'd254, 8'd1);
    directed[5] = make_pair(8'hAA, 8'h55, 8'h55, 8'hAA, 8'hF0, 8'h0F, 8'h0F, 8'hF0);
    mode_order  = '{MODE_ADD, MODE_SCREEN, MODE_DIFF, MODE_DODGE};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int m = 0; m < 4; m++) begin
      // The add mode is the reset value, so the first set runs without a write.
      if (mode_order[m] != MODE_ADD) write_mode(mode_order[m]);
      foreach (directed[i]) pair_q.push_back(directed[i]);
      wait_drained();
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      // The two extreme mode values get a random phase each for certain.
      if (ph == 0) phase_mode = MODE_DODGE;
      else if (ph == 1) phase_mode = MODE_ADD;
      else phase_mode = blend_mode_e'($urandom_range(0, 3));
      // Phase 2 runs with no idling at all; phase 5 only stalls on the result side.
      src_idle_en  = (ph != 2 && ph != 5);
      sink_idle_en = (ph != 2);
      write_mode(phase_mode);
      for (int i = 0; i < PhasePixels; i++) pair_q.push_back(random_pair());
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (blended_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", blended_q.size()));
    end

    $display("Blended %0d pixel pairs, %0d results checked, under modes %b after %0d mode writes.",
             pix_count, result_count, modes_seen, cfg_writes);
    $display("Input held back for %0d cycles by output back-pressure; %0d mismatches.",
             stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rbm_pkg.sv
rtl/core/rbm_prep.sv
rtl/core/rbm_cell.sv
rtl/core/rgba_blend_mode_unit.sv
tb/sv/rgba_blend_mode_unit_tb.sv
